/* rtl/itew_pkg.sv */
// shared types, word codes and helper functions for the integer to english words block
`default_nettype none
package itew_pkg;

  localparam int NUMBER_W  = 31;
  localparam int CODE_W    = 5;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W     = 4 * BCD_DIGITS;
  localparam int EXT_W     = 48;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [3:0]        digit_t;
  typedef logic [BCD_W-1:0]  bcd_t;
  typedef logic [EXT_W-1:0]  bcd_ext_t;
  typedef logic [1:0]        grp_t;
  typedef logic [2:0]        step_t;

  localparam code_t W_ZERO      = 5'd0;
  localparam code_t W_TEN       = 5'd10;
  localparam code_t W_TENS_BASE = 5'd18;
  localparam code_t W_HUNDRED   = 5'd28;
  localparam code_t W_THOUSAND  = 5'd29;
  localparam code_t W_MILLION   = 5'd30;
  localparam code_t W_BILLION   = 5'd31;

  localparam grp_t G_BILLION  = 2'd0;
  localparam grp_t G_MILLION  = 2'd1;
  localparam grp_t G_THOUSAND = 2'd2;
  localparam grp_t G_UNITS    = 2'd3;

  localparam step_t ST_HUND_DIGIT = 3'd0;
  localparam step_t ST_HUNDRED    = 3'd1;
  localparam step_t ST_TENS       = 3'd2;
  localparam step_t ST_UNITS      = 3'd3;
  localparam step_t ST_SCALE      = 3'd4;

  // one double dabble step: adjust digits, shift in one binary bit
  function automatic bcd_t dd_step(input bcd_t b, input logic bit_in);
    bcd_t adj;
    adj = b;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  // three decimal digits of one thousands group, hundreds digit on top
  function automatic logic [11:0] grp_digits(input bcd_ext_t d, input grp_t g);
    logic [11:0] r;
    case (g)
      G_BILLION:  r = d[47:36];
      G_MILLION:  r = d[35:24];
      G_THOUSAND: r = d[23:12];
      default:    r = d[11:0];
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/itew_fifo.sv */
// two-entry request queue between the converter and the word sequencer
`default_nettype none
module itew_fifo #(
  parameter int WIDTH = 40
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/itew_front.sv */
// front end: accepts a number and converts it to decimal digits two bits per cycle
`default_nettype none
module itew_front
  import itew_pkg::*;
#(
  parameter int INPUT_BITS = 31
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [NUMBER_W-1:0] in_number,
  output logic                     push_valid,
  input  wire logic                push_ready,
  output bcd_t                     push_data
);

  localparam int PAD_BITS = INPUT_BITS + (INPUT_BITS % 2);
  localparam int HALF     = PAD_BITS / 2;
  localparam int CNT_W    = $clog2(HALF);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CONV = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PAD_BITS-1:0] val_r, val_nxt;
  bcd_t                bcd_r, bcd_nxt;
  logic [PAD_BITS-1:0] masked;

  // keep only the low INPUT_BITS bits of the request
  for (genvar i = 0; i < PAD_BITS; i++) begin : g_mask
    if (i < INPUT_BITS && i < NUMBER_W) begin : g_keep
      assign masked[i] = in_number[i];
    end else begin : g_zero
      assign masked[i] = 1'b0;
    end
  end

  assign in_ready   = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);
  assign push_data  = bcd_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    val_nxt   = val_r;
    bcd_nxt   = bcd_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          val_nxt   = masked;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = F_CONV;
        end
      end
      F_CONV: begin
        bcd_nxt = dd_step(dd_step(bcd_r, val_r[PAD_BITS-1]), val_r[PAD_BITS-2]);
        val_nxt = {val_r[PAD_BITS-3:0], 2'b00};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(HALF - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    bcd_r <= bcd_nxt;
  end

endmodule
`default_nettype wire

/* rtl/itew_back.sv */
// back end: walks the decimal groups and emits their word codes
`default_nettype none
module itew_back
  import itew_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic pop_valid,
  output logic      pop_ready,
  input  wire bcd_t pop_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output code_t     out_word_code,
  output logic      out_last_word
);

  logic     active_r, active_nxt;
  bcd_ext_t digits_r, digits_nxt;
  grp_t     grp_r, grp_nxt;
  step_t    step_r, step_nxt;
  logic     is_zero_r, is_zero_nxt;
  grp_t     last_grp_r, last_grp_nxt;
  step_t    last_step_r, last_step_nxt;
  logic     out_valid_r, out_valid_nxt;
  code_t    out_code_r, out_code_nxt;
  logic     out_last_r, out_last_nxt;

  bcd_ext_t    head_ext;
  logic [11:0] hg0, hg1, hg2, hg3;
  logic [11:0] cur;
  digit_t      h, t, u;
  logic        grp_nz;
  logic        can_go, emit, last;
  code_t       code;

  assign out_valid     = out_valid_r;
  assign out_word_code = out_code_r;
  assign out_last_word = out_last_r;
  assign pop_ready     = !active_r;

  assign head_ext = {{(EXT_W - BCD_W){1'b0}}, pop_data};
  assign hg0 = grp_digits(head_ext, G_BILLION);
  assign hg1 = grp_digits(head_ext, G_MILLION);
  assign hg2 = grp_digits(head_ext, G_THOUSAND);
  assign hg3 = grp_digits(head_ext, G_UNITS);

  assign cur    = grp_digits(digits_r, grp_r);
  assign h      = cur[11:8];
  assign t      = cur[7:4];
  assign u      = cur[3:0];
  assign grp_nz = (cur != 12'd0);
  assign can_go = active_r && (!out_valid_r || out_ready);
  assign last   = is_zero_r || ((grp_r == last_grp_r) && (step_r == last_step_r));

  // word for the current step, if any
  always_comb begin
    emit = 1'b0;
    code = W_ZERO;
    if (is_zero_r) begin
      emit = 1'b1;
    end else begin
      case (step_r)
        ST_HUND_DIGIT: begin
          emit = (h != 4'd0);
          code = {1'b0, h};
        end
        ST_HUNDRED: begin
          emit = (h != 4'd0);
          code = W_HUNDRED;
        end
        ST_TENS: begin
          if (t == 4'd1) begin
            emit = 1'b1;
            code = W_TEN + {1'b0, u};
          end else if (t >= 4'd2) begin
            emit = 1'b1;
            code = W_TENS_BASE + {1'b0, t};
          end
        end
        ST_UNITS: begin
          emit = (t != 4'd1) && (u != 4'd0);
          code = {1'b0, u};
        end
        ST_SCALE: begin
          emit = grp_nz && (grp_r != G_UNITS);
          case (grp_r)
            G_BILLION: code = W_BILLION;
            G_MILLION: code = W_MILLION;
            default:   code = W_THOUSAND;
          endcase
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    active_nxt    = active_r;
    digits_nxt    = digits_r;
    grp_nxt       = grp_r;
    step_nxt      = step_r;
    is_zero_nxt   = is_zero_r;
    last_grp_nxt  = last_grp_r;
    last_step_nxt = last_step_r;
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (!active_r) begin
      if (pop_valid) begin
        active_nxt    = 1'b1;
        digits_nxt    = head_ext;
        grp_nxt       = G_BILLION;
        step_nxt      = ST_HUND_DIGIT;
        is_zero_nxt   = 1'b0;
        last_step_nxt = ST_SCALE;
        // locate the final word of the request
        if (hg3 != 12'd0) begin
          last_grp_nxt = G_UNITS;
          if (hg3[7:4] == 4'd1) begin
            last_step_nxt = ST_TENS;
          end else if (hg3[3:0] != 4'd0) begin
            last_step_nxt = ST_UNITS;
          end else if (hg3[7:4] >= 4'd2) begin
            last_step_nxt = ST_TENS;
          end else begin
            last_step_nxt = ST_HUNDRED;
          end
        end else if (hg2 != 12'd0) begin
          last_grp_nxt = G_THOUSAND;
        end else if (hg1 != 12'd0) begin
          last_grp_nxt = G_MILLION;
        end else if (hg0 != 12'd0) begin
          last_grp_nxt = G_BILLION;
        end else begin
          last_grp_nxt = G_BILLION;
          is_zero_nxt  = 1'b1;
        end
      end
    end else if (can_go) begin
      if (emit) begin
        out_valid_nxt = 1'b1;
        out_code_nxt  = code;
        out_last_nxt  = last;
        if (last) begin
          active_nxt = 1'b0;
        end
      end
      if (step_r == ST_SCALE) begin
        step_nxt = ST_HUND_DIGIT;
        grp_nxt  = grp_r + 2'd1;
      end else begin
        step_nxt = step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digits_r    <= digits_nxt;
    grp_r       <= grp_nxt;
    step_r      <= step_nxt;
    is_zero_r   <= is_zero_nxt;
    last_grp_r  <= last_grp_nxt;
    last_step_r <= last_step_nxt;
    out_code_r  <= out_code_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule
`default_nettype wire

/* rtl/integer_to_english_word_tokens_top.sv */
// top level of the integer to english words block
//
// input channel: in_valid/in_ready with in_number, one request per number.
// output channel: out_valid/out_ready with out_word_code and out_last_word,
// one word code per transfer; out_last_word marks the final word of a number.
// the front end converts the number to ten decimal digits with a double
// dabble shifter, two bits per cycle, then hands them over into a
// two-entry queue. the back end loads a request from the queue, then
// steps through four groups of five word slots, one slot per cycle while
// its output word is not held by a low out_ready, and stops after the
// last word. a word reaches the output register the cycle after its slot
// is stepped. front and back run concurrently, so the front end can
// convert the next number while the back end emits words; the rate of
// numbers is set by whichever end is slower for that number.
// when out_ready is low the output register holds its word and the
// sequencer waits; the queue then fills and in_ready drops.
// reset empties the queue and both ends; nothing is kept between numbers.
`default_nettype none
module integer_to_english_word_tokens_top
  import itew_pkg::*;
#(
  parameter int INPUT_BITS = 31
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [NUMBER_W-1:0] in_number,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [CODE_W-1:0]        out_word_code,
  output logic                     out_last_word
);

  logic push_valid, push_ready;
  bcd_t push_data;
  logic pop_valid, pop_ready;
  bcd_t pop_data;

  itew_front #(
    .INPUT_BITS(INPUT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_number (in_number),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  itew_fifo #(
    .WIDTH(BCD_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  itew_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word_code(out_word_code),
    .out_last_word(out_last_word)
  );

endmodule
`default_nettype wire
